@@ rtl/agla_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agla_pkg
// Shared constants, types and register codes of the affine gap alignment cells.
// ----------------------------------------------------------------------------
package agla_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int SCORE_BITS = 24;
  localparam int FRAC_BITS  = 4;

  localparam int COL_IDX_W  = $clog2(MAX_COLS);
  localparam int PAIR_W     = 8;
  localparam int PEN_W      = 12;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 16;
  localparam int BEST_W     = SCORE_BITS - FRAC_BITS;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_PEN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_PEN   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LEN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LEN = CFG_IDX_W'(3);

  typedef logic [SCORE_BITS-1:0] score_t;

  typedef struct packed {
    score_t m;
    score_t ix;
    score_t iy;
  } cell_vals_t;

  // line store access control
  typedef struct packed {
    logic                 rd_en;
    logic [COL_IDX_W-1:0] rd_addr;
    logic                 wr_en;
    logic [COL_IDX_W-1:0] wr_addr;
  } line_ctl_t;

endpackage

@@ rtl/agla_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agla_if
// Valid/ready channels: cell request in, cell result out, register writes.
// ----------------------------------------------------------------------------
interface agla_in_if;
  import agla_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [PAIR_W-1:0] pair_score;
  modport source (output valid, output pair_score, input ready);
  modport sink   (input valid, input pair_score, output ready);
endinterface

interface agla_out_if;
  import agla_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [SCORE_BITS-1:0] m_value;
  logic [SCORE_BITS-1:0] ix_value;
  logic [SCORE_BITS-1:0] iy_value;
  logic [ROW_W-1:0]      cell_row;
  logic [COL_W-1:0]      cell_col;
  logic [BEST_W-1:0]     best_value;
  logic [ROW_W-1:0]      best_row;
  logic [COL_W-1:0]      best_col;
  logic                  matrix_done;
  modport source (output valid, output m_value, output ix_value, output iy_value,
                  output cell_row, output cell_col, output best_value,
                  output best_row, output best_col, output matrix_done,
                  input ready);
  modport sink   (input valid, input m_value, input ix_value, input iy_value,
                  input cell_row, input cell_col, input best_value,
                  input best_row, input best_col, input matrix_done,
                  output ready);
endinterface

interface agla_cfg_if;
  import agla_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/agla_line_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agla_line_store
// Previous-row store of M, Ix and Iy with registered read, same-edge write
// forwarding and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module agla_line_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  agla_pkg::line_ctl_t  ctl,
  input  agla_pkg::cell_vals_t wr_data,
  output agla_pkg::cell_vals_t rd_data,
  output logic                 busy
);
  import agla_pkg::*;

  cell_vals_t           mem [MAX_COLS];
  cell_vals_t           rd_r;
  cell_vals_t           fwd_data_r;
  logic                 fwd_r;
  logic                 clr_active_r;
  logic [COL_IDX_W-1:0] clr_addr_r;

  logic                 wr_en;
  logic [COL_IDX_W-1:0] wr_addr;
  cell_vals_t           wr_val;

  always_comb begin
    wr_en   = clr_active_r | ctl.wr_en;
    wr_addr = clr_active_r ? clr_addr_r : ctl.wr_addr;
    wr_val  = clr_active_r ? '0 : wr_data;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_val;
    end
    if (ctl.rd_en) begin
      rd_r       <= mem[ctl.rd_addr];
      fwd_data_r <= wr_val;
    end
  end

  // read and write of the same entry on one edge: take the new value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (ctl.rd_en) begin
      fwd_r <= wr_en && (wr_addr == ctl.rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == COL_IDX_W'(MAX_COLS - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_r;
  assign busy    = clr_active_r;

endmodule

@@ rtl/agla_cell_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agla_cell_calc
// One cell of the affine gap recurrences: M from the diagonal, Ix from the
// left, Iy from above, floored at zero and saturated at the top.
// ----------------------------------------------------------------------------
module agla_cell_calc (
  input  logic signed [agla_pkg::PAIR_W-1:0] pair_score,
  input  logic                               first_col,
  input  logic [agla_pkg::PEN_W-1:0]         open_pen,
  input  logic [agla_pkg::PEN_W-1:0]         ext_pen,
  input  agla_pkg::cell_vals_t               above,
  input  agla_pkg::cell_vals_t               left,
  input  agla_pkg::cell_vals_t               diag,
  output agla_pkg::cell_vals_t               result
);
  import agla_pkg::*;

  localparam int SW = SCORE_BITS + 2;
  localparam logic signed [SW-1:0] VAL_MAX = SW'((64'd1 << SCORE_BITS) - 64'd1);

  function automatic score_t max2(input score_t a, input score_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic score_t clamp(input logic signed [SW-1:0] v);
    score_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > VAL_MAX) begin
      r = VAL_MAX[SCORE_BITS-1:0];
    end else begin
      r = v[SCORE_BITS-1:0];
    end
    return r;
  endfunction

  cell_vals_t               l_eff;
  cell_vals_t               d_eff;
  score_t                   d_max;
  score_t                   l_open_src;
  score_t                   a_open_src;
  logic signed [SW-1:0]     score_fx;
  logic signed [SW-1:0]     oe;
  logic signed [SW-1:0]     ext;
  logic signed [SW-1:0]     m_sum;
  logic signed [SW-1:0]     ix_a;
  logic signed [SW-1:0]     ix_b;
  logic signed [SW-1:0]     iy_a;
  logic signed [SW-1:0]     iy_b;

  always_comb begin
    l_eff      = first_col ? '0 : left;
    d_eff      = first_col ? '0 : diag;
    score_fx   = SW'(pair_score) <<< FRAC_BITS;
    ext        = SW'(ext_pen);
    oe         = SW'(open_pen) + SW'(ext_pen);

    d_max      = max2(max2(d_eff.m, d_eff.ix), d_eff.iy);
    m_sum      = SW'(d_max) + score_fx;

    // both open paths share the same penalty
    l_open_src = max2(l_eff.m, l_eff.iy);
    ix_a       = SW'(l_open_src) - oe;
    ix_b       = SW'(l_eff.ix) - ext;

    a_open_src = max2(above.m, above.ix);
    iy_a       = SW'(a_open_src) - oe;
    iy_b       = SW'(above.iy) - ext;

    result.m   = clamp(m_sum);
    result.ix  = clamp((ix_a > ix_b) ? ix_a : ix_b);
    result.iy  = clamp((iy_a > iy_b) ? iy_a : iy_b);
  end

endmodule

@@ rtl/affine_gap_local_alignment_cells.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_gap_local_alignment_cells
// Local alignment matrix fill with affine gaps, one cell per request.
// ----------------------------------------------------------------------------
// Each request carries the integer substitution score of one cell, cells in
// row-major order (rows 1..lower_length, columns 1..upper_length). The block
// returns M, Ix and Iy for that cell (unsigned, 4 fraction bits, floored at
// zero, saturating), the cell position, and the first strictly greatest
// integer part of max(M, Ix, Iy) seen so far in this matrix with its position;
// matrix_done marks the last cell, after which counters and best tracking
// restart. One cell is accepted every clock while the result is not stalled;
// each passes the input register, then the result register. The previous-row
// store has one read and one write port; it is read when a request is taken
// and forwards a same-cycle write, so even one-column rows run at full rate.
// After reset the store is zeroed in a sweep over all 1024 entries, during
// which no cell request is accepted; register writes are taken at any time,
// but lengths and penalties should only change while no cell is in flight.
// ----------------------------------------------------------------------------
module affine_gap_local_alignment_cells (
  input  logic              clk,
  input  logic              rst_n,
  agla_in_if.sink           in_chan,
  agla_out_if.source        out_chan,
  agla_cfg_if.sink          cfg_chan
);
  import agla_pkg::*;

  // configuration registers
  logic [PEN_W-1:0]     open_pen_r;
  logic [PEN_W-1:0]     ext_pen_r;
  logic [COL_W-1:0]     upper_len_r;
  logic [ROW_W-1:0]     lower_len_r;

  // position of the next cell to be accepted
  logic [COL_W-1:0]     col_r;
  logic [ROW_W-1:0]     row_r;
  logic                 first_row_r;

  // input register stage
  logic                 s1_valid_r;
  logic [PAIR_W-1:0]    s1_score_r;
  logic [COL_W-1:0]     s1_col_r;
  logic [ROW_W-1:0]     s1_row_r;
  logic                 s1_first_row_r;
  logic                 s1_first_col_r;
  logic                 s1_done_r;

  // neighbours of the cell in the input register
  cell_vals_t           left_r;
  cell_vals_t           diag_r;

  // best tracking
  logic [BEST_W-1:0]    best_val_r;
  logic [ROW_W-1:0]     best_row_r;
  logic [COL_W-1:0]     best_col_r;
  logic                 no_best_r;

  // result register
  logic                 o_valid_r;
  cell_vals_t           o_vals_r;
  logic [ROW_W-1:0]     o_row_r;
  logic [COL_W-1:0]     o_col_r;
  logic [BEST_W-1:0]    o_best_val_r;
  logic [ROW_W-1:0]     o_best_row_r;
  logic [COL_W-1:0]     o_best_col_r;
  logic                 o_done_r;

  logic                 clr_busy;
  logic                 in_acc;
  logic                 s2_free;
  logic                 s1_adv;
  logic [COL_W-1:0]     eff_upper;
  logic [ROW_W-1:0]     eff_lower;
  logic                 row_end;
  logic                 done_nxt;
  line_ctl_t            line_ctl;
  cell_vals_t           line_rd;
  cell_vals_t           above_eff;
  cell_vals_t           cell_res;
  score_t               cell_max;
  logic [BEST_W-1:0]    cell_int;
  logic                 take_best;

  // handshake: result register parts the two sides
  assign s2_free         = !o_valid_r || out_chan.ready;
  assign s1_adv          = s1_valid_r && s2_free;
  assign in_chan.ready   = !clr_busy && (!s1_valid_r || s2_free);
  assign in_acc          = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready  = 1'b1;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_pen_r   <= PEN_W'(160);
      ext_pen_r    <= PEN_W'(8);
      upper_len_r  <= COL_W'(1024);
      lower_len_r  <= ROW_W'(1);
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        CFG_OPEN_PEN:   open_pen_r   <= cfg_chan.data[PEN_W-1:0];
        CFG_EXT_PEN:    ext_pen_r    <= cfg_chan.data[PEN_W-1:0];
        CFG_UPPER_LEN:  upper_len_r  <= cfg_chan.data[COL_W-1:0];
        CFG_LOWER_LEN:  lower_len_r  <= cfg_chan.data[ROW_W-1:0];
        default:        open_pen_r   <= open_pen_r;
      endcase
    end
  end

  // zero lengths act as one, row length capped at store depth
  always_comb begin
    if (upper_len_r == '0) begin
      eff_upper = COL_W'(1);
    end else if (upper_len_r > COL_W'(MAX_COLS)) begin
      eff_upper = COL_W'(MAX_COLS);
    end else begin
      eff_upper = upper_len_r;
    end
    eff_lower = (lower_len_r == '0) ? ROW_W'(1) : lower_len_r;
    row_end   = (col_r >= eff_upper);
    done_nxt  = row_end && (row_r >= eff_lower);
  end

  // cell position stepping at request acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= COL_W'(1);
      row_r       <= ROW_W'(1);
      first_row_r <= 1'b1;
    end else if (in_acc) begin
      if (done_nxt) begin
        col_r       <= COL_W'(1);
        row_r       <= ROW_W'(1);
        first_row_r <= 1'b1;
      end else if (row_end) begin
        col_r       <= COL_W'(1);
        row_r       <= row_r + 1'b1;
        first_row_r <= 1'b0;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_score_r     <= in_chan.pair_score;
      s1_col_r       <= col_r;
      s1_row_r       <= row_r;
      s1_first_row_r <= first_row_r;
      s1_first_col_r <= (col_r <= COL_W'(1));
      s1_done_r      <= done_nxt;
    end
  end

  // previous row: read at acceptance, written when the cell completes
  always_comb begin
    line_ctl.rd_en   = in_acc;
    line_ctl.rd_addr = COL_IDX_W'(col_r - 1'b1);
    line_ctl.wr_en   = s1_adv;
    line_ctl.wr_addr = COL_IDX_W'(s1_col_r - 1'b1);
  end

  agla_line_store u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (line_ctl),
    .wr_data (cell_res),
    .rd_data (line_rd),
    .busy    (clr_busy)
  );

  // first row sees zeros above
  assign above_eff = s1_first_row_r ? '0 : line_rd;

  agla_cell_calc u_cell_calc (
    .pair_score (s1_score_r),
    .first_col  (s1_first_col_r),
    .open_pen   (open_pen_r),
    .ext_pen    (ext_pen_r),
    .above      (above_eff),
    .left       (left_r),
    .diag       (diag_r),
    .result     (cell_res)
  );

  // this cell becomes the left neighbour, its above value the next diagonal
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_r <= cell_res;
      diag_r <= above_eff;
    end
  end

  // integer part of the cell maximum
  always_comb begin
    cell_max = cell_res.m;
    if (cell_res.ix > cell_max) begin
      cell_max = cell_res.ix;
    end
    if (cell_res.iy > cell_max) begin
      cell_max = cell_res.iy;
    end
    cell_int  = cell_max[SCORE_BITS-1:FRAC_BITS];
    take_best = no_best_r || (cell_int > best_val_r);
  end

  // best tracking, restarted after the last cell of a matrix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_best_r  <= 1'b1;
      best_val_r <= '0;
      best_row_r <= '0;
      best_col_r <= '0;
    end else if (s1_adv) begin
      if (s1_done_r) begin
        no_best_r  <= 1'b1;
        best_val_r <= '0;
        best_row_r <= '0;
        best_col_r <= '0;
      end else if (take_best) begin
        no_best_r  <= 1'b0;
        best_val_r <= cell_int;
        best_row_r <= s1_row_r;
        best_col_r <= s1_col_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (s1_adv) begin
      o_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_vals_r     <= cell_res;
      o_row_r      <= s1_row_r;
      o_col_r      <= s1_col_r;
      o_best_val_r <= take_best ? cell_int : best_val_r;
      o_best_row_r <= take_best ? s1_row_r : best_row_r;
      o_best_col_r <= take_best ? s1_col_r : best_col_r;
      o_done_r     <= s1_done_r;
    end
  end

  assign out_chan.valid       = o_valid_r;
  assign out_chan.m_value     = o_vals_r.m;
  assign out_chan.ix_value    = o_vals_r.ix;
  assign out_chan.iy_value    = o_vals_r.iy;
  assign out_chan.cell_row    = o_row_r;
  assign out_chan.cell_col    = o_col_r;
  assign out_chan.best_value  = o_best_val_r;
  assign out_chan.best_row    = o_best_row_r;
  assign out_chan.best_col    = o_best_col_r;
  assign out_chan.matrix_done = o_done_r;

  // no request taken while the previous-row store is being zeroed
  assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_chan.ready)
    else $error("request accepted during line store clear");

  // a cell held in the input register stays while the result is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_free) |=> (s1_valid_r && $stable(s1_col_r) && $stable(s1_row_r)))
    else $error("input stage cell lost under stall");

  // the reported best covers the M value of the cell it is reported with
  assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> (o_best_val_r >= o_vals_r.m[SCORE_BITS-1:FRAC_BITS]))
    else $error("best value below current cell");

  // the best row never lies after the current cell's row in its matrix
  assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r |-> (o_best_row_r <= o_row_r))
    else $error("best row after current cell");

endmodule

@@ tb/affine_gap_local_alignment_cells_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_gap_local_alignment_cells_tb
// Self-checking bench for the affine gap local alignment cell engine. Cell
// requests are streamed in row-major order, each result is checked field by
// field against an in-bench alignment predictor. Directed matrices cover
// score and penalty extremes, best tie handling, length corners and
// mid-matrix length changes. Random matrices run under four idle/stall mixes.
// ----------------------------------------------------------------------------
module affine_gap_local_alignment_cells_tb;
  import agla_pkg::*;

  localparam longint SAT_TOP = (longint'(1) << SCORE_BITS) - 1;

  // one expected cell result
  typedef struct packed {
    score_t             m;
    score_t             ix;
    score_t             iy;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [BEST_W-1:0]  best;
    logic [ROW_W-1:0]   best_row;
    logic [COL_W-1:0]   best_col;
    logic               done;
  } cell_result_t;

  logic clk;
  logic rst_n;

  agla_in_if  in_bus ();
  agla_out_if out_bus ();
  agla_cfg_if cfg_bus ();

  affine_gap_local_alignment_cells dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  // predictor registers, as last written
  logic [PEN_W-1:0] open_pen;
  logic [PEN_W-1:0] ext_pen;
  logic [COL_W-1:0] upper_len;
  logic [ROW_W-1:0] lower_len;

  // predictor state: previous row, left and diagonal neighbours, position
  score_t            above_m [MAX_COLS];
  score_t            above_ix [MAX_COLS];
  score_t            above_iy [MAX_COLS];
  score_t            left_m, left_ix, left_iy;
  score_t            diag_m, diag_ix, diag_iy;
  logic [ROW_W-1:0]  row_at;
  logic [COL_W-1:0]  col_at;
  logic [BEST_W-1:0] best_int;
  bit                best_empty;
  logic [ROW_W-1:0]  best_row_at;
  logic [COL_W-1:0]  best_col_at;
  bit                on_top_row;
  bit                last_done;

  cell_result_t cells_due[$];   // predicted cells waiting for their result
  int unsigned  cells_sent;
  int unsigned  bad_cells;
  int unsigned  idle_pct;
  int unsigned  stall_pct;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  function automatic score_t floor_sat(longint v);
    if (v < 0) return '0;
    if (v > SAT_TOP) return '1;
    return score_t'(v);
  endfunction

  function automatic longint top3(longint a, longint b, longint c);
    longint t;
    t = (a > b) ? a : b;
    return (c > t) ? c : t;
  endfunction

  function automatic void restart_matrix();
    row_at      = 1;
    col_at      = 1;
    best_int    = '0;
    best_empty  = 1'b1;
    best_row_at = '0;
    best_col_at = '0;
    on_top_row  = 1'b1;
    left_m  = '0; left_ix = '0; left_iy = '0;
    diag_m  = '0; diag_ix = '0; diag_iy = '0;
  endfunction

  function automatic void reset_predictor();
    open_pen  = 160;
    ext_pen   = 8;
    upper_len = 1024;
    lower_len = 1;
    for (int i = 0; i < MAX_COLS; i++) begin
      above_m[i]  = '0;
      above_ix[i] = '0;
      above_iy[i] = '0;
    end
    restart_matrix();
    last_done = 1'b0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_OPEN_PEN:   open_pen  = d[PEN_W-1:0];
      CFG_EXT_PEN:    ext_pen   = d[PEN_W-1:0];
      CFG_UPPER_LEN:  upper_len = d[COL_W-1:0];
      CFG_LOWER_LEN:  lower_len = d[ROW_W-1:0];
      default: ;
    endcase
  endfunction

  // computes one cell from its score and queues the expected result
  function automatic void fill_cell(logic signed [PAIR_W-1:0] s);
    int unsigned  up_eff, low_eff, slot;
    bit           first_col, row_end, done;
    longint       sc, ext, oe;
    longint       am, aix, aiy, lm, lix, liy, dm, dix, diy;
    score_t       m, ix, iy, mx;
    logic [BEST_W-1:0] whole;
    cell_result_t r;
    up_eff  = (upper_len == 0) ? 1 : upper_len;
    if (up_eff > MAX_COLS) up_eff = MAX_COLS;
    low_eff = (lower_len == 0) ? 1 : lower_len;
    first_col = (col_at <= 1);
    sc  = longint'(s) * (longint'(1) << FRAC_BITS);
    ext = longint'(ext_pen);
    oe  = longint'(open_pen) + ext;
    slot = (col_at == 0) ? 0 : col_at - 1;
    if (slot >= MAX_COLS) slot = MAX_COLS - 1;

    // row 0 and column 0 count as zero
    if (on_top_row) begin
      am = 0; aix = 0; aiy = 0;
    end else begin
      am  = longint'(above_m[slot]);
      aix = longint'(above_ix[slot]);
      aiy = longint'(above_iy[slot]);
    end
    if (first_col) begin
      lm = 0; lix = 0; liy = 0; dm = 0; dix = 0; diy = 0;
    end else begin
      lm = longint'(left_m); lix = longint'(left_ix); liy = longint'(left_iy);
      dm = longint'(diag_m); dix = longint'(diag_ix); diy = longint'(diag_iy);
    end

    m  = floor_sat(top3(dm, dix, diy) + sc);
    ix = floor_sat(top3(lm - oe, lix - ext, liy - oe));
    iy = floor_sat(top3(am - oe, aiy - ext, aix - oe));

    // first strictly greatest integer part wins
    mx = (m > ix) ? m : ix;
    if (iy > mx) mx = iy;
    whole = mx[SCORE_BITS-1:FRAC_BITS];
    if (best_empty || whole > best_int) begin
      best_int    = whole;
      best_row_at = row_at;
      best_col_at = col_at;
      best_empty  = 1'b0;
    end

    row_end = (col_at >= up_eff);
    done    = row_end && (row_at >= low_eff);

    r.m        = m;
    r.ix       = ix;
    r.iy       = iy;
    r.row      = row_at;
    r.col      = col_at;
    r.best     = best_int;
    r.best_row = best_row_at;
    r.best_col = best_col_at;
    r.done     = done;
    cells_due.push_back(r);

    above_m[slot]  = m;
    above_ix[slot] = ix;
    above_iy[slot] = iy;
    diag_m  = score_t'(am); diag_ix = score_t'(aix); diag_iy = score_t'(aiy);
    left_m  = m; left_ix = ix; left_iy = iy;

    if (done) begin
      restart_matrix();
    end else if (row_end) begin
      col_at     = 1;
      row_at     = row_at + 1'b1;
      on_top_row = 1'b0;
    end else begin
      col_at = col_at + 1'b1;
    end
    last_done = done;
  endfunction

  // --------------------------------------------------------------------------
  // clock and result side
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial out_bus.ready = 1'b0;
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void check_field(string what, logic [SCORE_BITS-1:0] want,
                                      logic [SCORE_BITS-1:0] got);
    if (want !== got) begin
      bad_cells++;
      if (bad_cells <= 10)
        $display("mismatch %s: expected %0d, got %0d", what, want, got);
    end
  endfunction

  // every accepted result against the oldest prediction
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (cells_due.size() == 0) begin
        bad_cells++;
        if (bad_cells <= 10)
          $display("unexpected result at row %0d col %0d", out_bus.cell_row,
                   out_bus.cell_col);
      end else begin
        want = cells_due.pop_front();
        check_field("m_value",     want.m,        out_bus.m_value);
        check_field("ix_value",    want.ix,       out_bus.ix_value);
        check_field("iy_value",    want.iy,       out_bus.iy_value);
        check_field("cell_row",    SCORE_BITS'(want.row), SCORE_BITS'(out_bus.cell_row));
        check_field("cell_col",    SCORE_BITS'(want.col), SCORE_BITS'(out_bus.cell_col));
        check_field("best_value",  SCORE_BITS'(want.best),
                    SCORE_BITS'(out_bus.best_value));
        check_field("best_row",    SCORE_BITS'(want.best_row),
                    SCORE_BITS'(out_bus.best_row));
        check_field("best_col",    SCORE_BITS'(want.best_col),
                    SCORE_BITS'(out_bus.best_col));
        check_field("matrix_done", SCORE_BITS'(want.done),
                    SCORE_BITS'(out_bus.matrix_done));
      end
    end
  end

  // --------------------------------------------------------------------------
  // request side; all tasks start and end at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_cell(input logic signed [PAIR_W-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid      <= 1'b0;
      in_bus.pair_score <= PAIR_W'($urandom);
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.pair_score <= s;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    fill_cell(s);
    cells_sent++;
    @(negedge clk);
  endtask

  // drop the request and let every predicted cell come back
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (cells_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    apply_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] open, input logic [CFG_DATA_W-1:0] ext,
                            input logic [CFG_DATA_W-1:0] up, input logic [CFG_DATA_W-1:0] low);
    wait_idle();
    write_reg(CFG_OPEN_PEN, open);
    write_reg(CFG_EXT_PEN, ext);
    write_reg(CFG_UPPER_LEN, up);
    write_reg(CFG_LOWER_LEN, low);
    cfg_bus.valid <= 1'b0;
  endtask

  // mostly small positive scores so values build up, some full-range
  function automatic logic signed [PAIR_W-1:0] rand_score();
    case ($urandom_range(3))
      0:       return PAIR_W'($urandom);
      1:       return PAIR_W'($urandom_range(0, 40));
      default: return PAIR_W'(int'($urandom_range(0, 32)) - 12);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_pen(int unsigned top);
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, top));
    endcase
  endfunction

  // random scores until the last cell of the current matrix
  task automatic finish_matrix();
    do send_cell(rand_score()); while (!last_done);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // registers at reset: one full row of 1024 cells
  task automatic test_reset_registers();
    finish_matrix();
  endtask

  // score extremes feeding the diagonal chain, flooring at zero
  task automatic test_score_extremes();
    set_config(160, 8, 2, 2);
    send_cell(127);
    send_cell(-128);
    send_cell(-1);
    send_cell(127);
  endtask

  // zero penalties let gaps carry values, all-ones data masks to the top
  task automatic test_gap_penalties();
    set_config(0, 0, 2, 2);
    send_cell(100);
    send_cell(-50);
    send_cell(-128);
    send_cell(127);
    set_config(16'hFFFF, 16'hFFFF, 2, 2);
    send_cell(127);
    send_cell(127);
    send_cell(127);
    send_cell(127);
  endtask

  // equal integer parts later in the matrix do not move the best cell
  task automatic test_best_ties();
    set_config(160, 8, 4, 1);
    send_cell(5);
    send_cell(5);
    send_cell(3);
    send_cell(5);
  endtask

  // zero lengths act as one: every cell is a whole matrix; the first cell
  // is always best, even at zero
  task automatic test_length_zero();
    set_config(160, 8, 0, 0);
    send_cell(127);
    send_cell(-128);
  endtask

  // lengths changed between cells of one matrix
  task automatic test_length_change();
    // upper masks to 2047 and clamps to the store depth, lower at its top
    set_config(160, 8, 16'hFFFF, 16'hFFFF);
    send_cell(40);
    send_cell(40);
    send_cell(40);
    // row already past the new length ends on the next cell
    set_config(160, 8, 2, 2);
    finish_matrix();
    // rows of one cell, then a lower length already passed
    set_config(160, 8, 1, 65535);
    send_cell(20);
    send_cell(20);
    send_cell(20);
    set_config(160, 8, 1, 2);
    finish_matrix();
  endtask

  task automatic run_matrix();
    do send_cell(rand_score()); while (!last_done && ($urandom_range(3) != 0));
    // now and then a new shape part way through
    if (!last_done && ($urandom_range(7) == 0))
      set_config(open_pen, ext_pen, CFG_DATA_W'($urandom_range(0, 20)),
                 CFG_DATA_W'($urandom_range(0, 12)));
    if (!last_done) finish_matrix();
  endtask

  task automatic test_random_matrices();
    int unsigned phase_start;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 61; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      phase_start = cells_sent;
      while (cells_sent - phase_start < 170) begin
        if ($urandom_range(2) != 0)
          set_config(rand_pen(400), rand_pen(64), CFG_DATA_W'($urandom_range(0, 20)),
                     CFG_DATA_W'($urandom_range(0, 12)));
        run_matrix();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.pair_score = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = CFG_OPEN_PEN;
    cfg_bus.data      = '0;
    idle_pct          = 0;
    stall_pct         = 0;
    cells_sent        = 0;
    bad_cells         = 0;
    reset_predictor();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // requests wait out the store clearing sweep on ready
    test_reset_registers();
    test_score_extremes();
    test_gap_penalties();
    test_best_ties();
    test_length_zero();
    test_length_change();
    test_random_matrices();

    // drain, then wait for any stray result
    wait_idle();
    repeat (4) @(negedge clk);
    if (bad_cells == 0)
      $display("affine_gap_local_alignment_cells_tb OK");
    else
      $display("affine_gap_local_alignment_cells_tb NOT OK");
    $finish;
  end

  // hang guard
  initial begin
    #3000000;
    $display("affine_gap_local_alignment_cells_tb NOT OK");
    $finish;
  end

endmodule
